@@ design/mdwus_pkg.sv @@
// shared types and constants for the disjoint word union search block
// no dependencies

package mdwus_pkg;

	localparam int unsigned LETTERS = 26;
	localparam int unsigned CODE_W = 5;
	localparam int unsigned MASK_W = 26;
	localparam int unsigned LEN_W = 5;
	localparam int unsigned ENTRY_W = MASK_W + LEN_W;

	typedef logic [CODE_W-1:0] code_t;
	typedef logic [MASK_W-1:0] mask_t;
	typedef logic [LEN_W-1:0] len_t;

	// one stored word: letter count and letter mask
	typedef struct packed {
		len_t len;
		mask_t mask;
	} word_entry_t;

	typedef enum logic [2:0] {
		SRCH_IDLE,
		SRCH_READ,
		SRCH_EVAL,
		SRCH_POP,
		SRCH_DONE
	} srch_state_t;

	// search status toward the top level
	typedef struct packed {
		logic busy;
		logic done;
		len_t best;
	} srch_status_t;

endpackage

@@ design/mdwus_if.sv @@
// valid/ready channel interfaces for letter items and result items
// depends on mdwus_pkg

interface mdwus_in_if;
	logic valid;
	logic ready;
	mdwus_pkg::code_t letter_index;
	logic word_end;
	logic list_end;

	modport source(output valid, output letter_index, output word_end, output list_end,
		input ready);
	modport sink(input valid, input letter_index, input word_end, input list_end,
		output ready);
endinterface

interface mdwus_out_if;
	logic valid;
	logic ready;
	mdwus_pkg::len_t max_length;
	logic words_dropped;

	modport source(output valid, output max_length, output words_dropped, input ready);
	modport sink(input valid, input max_length, input words_dropped, output ready);
endinterface

@@ design/mdwus_ram.sv @@
// simple dual-port synchronous memory, one write and one registered read port
// no dependencies

module mdwus_ram #(
	parameter int WIDTH = 31,
	parameter int DEPTH = 16,
	parameter int ADDR_W = 4
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ design/mdwus_word_builder.sv @@
// assembles letter masks per word and appends repeat-free words to the word store
// depends on mdwus_pkg

module mdwus_word_builder #(
	parameter int MAX_WORDS = 16,
	parameter int CNT_W = 5,
	parameter int ADDR_W = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  accept,
	input  mdwus_pkg::code_t      letter_index,
	input  logic                  word_end,
	input  logic                  list_end,
	input  logic                  clear,
	output logic                  wr_en,
	output logic [ADDR_W-1:0]     wr_addr,
	output mdwus_pkg::word_entry_t wr_data,
	output logic [CNT_W-1:0]      word_count,
	output logic                  overflow
);

	mdwus_pkg::mask_t mask_q;
	mdwus_pkg::len_t len_q;
	logic rep_q;
	logic [CNT_W-1:0] count_q;
	logic overflow_q;

	logic in_range;
	logic hit;
	logic word_close;
	logic keep;
	logic full;
	mdwus_pkg::mask_t bit_v;
	mdwus_pkg::mask_t new_mask;
	mdwus_pkg::len_t new_len;
	logic new_rep;

	always_comb begin
		in_range = letter_index < mdwus_pkg::CODE_W'(mdwus_pkg::LETTERS);
		bit_v = in_range ? (mdwus_pkg::MASK_W'(1) << letter_index) : '0;
		hit = |(mask_q & bit_v);
		new_mask = mask_q | bit_v;
		new_rep = rep_q | hit;
		// only new letters count, so the length equals the mask's popcount
		new_len = len_q + mdwus_pkg::LEN_W'(in_range && !hit);
		word_close = accept && (word_end || list_end);
		keep = !new_rep && (|new_mask);
		full = count_q >= CNT_W'(MAX_WORDS);
		wr_en = word_close && keep && !full;
		wr_addr = count_q[ADDR_W-1:0];
		wr_data.len = new_len;
		wr_data.mask = new_mask;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
			len_q <= '0;
			rep_q <= 1'b0;
			count_q <= '0;
			overflow_q <= 1'b0;
		end else if (clear) begin
			count_q <= '0;
			overflow_q <= 1'b0;
		end else if (word_close) begin
			mask_q <= '0;
			len_q <= '0;
			rep_q <= 1'b0;
			if (wr_en) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (keep && full) begin
				overflow_q <= 1'b1;
			end
		end else if (accept) begin
			mask_q <= new_mask;
			len_q <= new_len;
			rep_q <= new_rep;
		end
	end

	assign word_count = count_q;
	assign overflow = overflow_q;

endmodule

@@ design/mdwus_search.sv @@
// depth-first search sequencer over the word store with a frame stack in memory
// depends on mdwus_pkg and mdwus_ram

module mdwus_search #(
	parameter int MAX_WORDS = 16,
	parameter int CNT_W = 5,
	parameter int ADDR_W = 4
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic                   out_free,
	input  logic [CNT_W-1:0]       word_count,
	output logic [ADDR_W-1:0]      word_raddr,
	input  mdwus_pkg::word_entry_t word_rdata,
	output mdwus_pkg::srch_status_t status
);

	localparam int FRAME_W = mdwus_pkg::MASK_W + mdwus_pkg::LEN_W + CNT_W;

	mdwus_pkg::srch_state_t state_q, state_d;

	mdwus_pkg::mask_t union_q;
	mdwus_pkg::len_t len_q;
	mdwus_pkg::len_t best_q;
	logic [CNT_W-1:0] idx_q;
	logic [CNT_W-1:0] sp_q;

	logic stk_we;
	logic [ADDR_W-1:0] stk_waddr;
	logic [ADDR_W-1:0] stk_raddr;
	logic [FRAME_W-1:0] stk_wdata;
	logic [FRAME_W-1:0] stk_rdata;

	logic [CNT_W-1:0] sp_dec;
	logic disjoint;
	mdwus_pkg::len_t sum_len;

	mdwus_ram #(
		.WIDTH(FRAME_W),
		.DEPTH(MAX_WORDS),
		.ADDR_W(ADDR_W)
	) u_stack (
		.clk(clk),
		.we(stk_we),
		.waddr(stk_waddr),
		.wdata(stk_wdata),
		.raddr(stk_raddr),
		.rdata(stk_rdata)
	);

	always_comb begin
		state_d = state_q;
		sp_dec = sp_q - CNT_W'(1);
		disjoint = ~|(word_rdata.mask & union_q);
		sum_len = len_q + word_rdata.len;
		word_raddr = idx_q[ADDR_W-1:0];
		stk_raddr = sp_dec[ADDR_W-1:0];
		stk_waddr = sp_q[ADDR_W-1:0];
		// parent frame resumes at the next candidate
		stk_wdata = {union_q, len_q, idx_q + CNT_W'(1)};
		stk_we = 1'b0;
		status.busy = state_q != mdwus_pkg::SRCH_IDLE;
		status.done = 1'b0;
		status.best = best_q;
		case (state_q)
			mdwus_pkg::SRCH_IDLE: begin
				if (start) begin
					state_d = mdwus_pkg::SRCH_READ;
				end
			end
			mdwus_pkg::SRCH_READ: begin
				if (idx_q < word_count) begin
					state_d = mdwus_pkg::SRCH_EVAL;
				end else if (sp_q == '0) begin
					state_d = mdwus_pkg::SRCH_DONE;
				end else begin
					state_d = mdwus_pkg::SRCH_POP;
				end
			end
			mdwus_pkg::SRCH_EVAL: begin
				stk_we = disjoint;
				if (disjoint && sum_len >= mdwus_pkg::LEN_W'(mdwus_pkg::LETTERS)) begin
					state_d = mdwus_pkg::SRCH_DONE;
				end else begin
					state_d = mdwus_pkg::SRCH_READ;
				end
			end
			mdwus_pkg::SRCH_POP: begin
				state_d = mdwus_pkg::SRCH_READ;
			end
			mdwus_pkg::SRCH_DONE: begin
				status.done = out_free;
				if (out_free) begin
					state_d = mdwus_pkg::SRCH_IDLE;
				end
			end
			default: begin
				state_d = mdwus_pkg::SRCH_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mdwus_pkg::SRCH_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			union_q <= '0;
			len_q <= '0;
			best_q <= '0;
			idx_q <= '0;
			sp_q <= '0;
		end else begin
			case (state_q)
				mdwus_pkg::SRCH_IDLE: begin
					if (start) begin
						union_q <= '0;
						len_q <= '0;
						best_q <= '0;
						idx_q <= '0;
						sp_q <= '0;
					end
				end
				mdwus_pkg::SRCH_EVAL: begin
					idx_q <= idx_q + CNT_W'(1);
					if (disjoint) begin
						union_q <= union_q | word_rdata.mask;
						len_q <= sum_len;
						sp_q <= sp_q + CNT_W'(1);
						if (sum_len > best_q) begin
							best_q <= sum_len;
						end
					end
				end
				mdwus_pkg::SRCH_POP: begin
					{union_q, len_q, idx_q} <= stk_rdata;
					sp_q <= sp_dec;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

@@ design/max_disjoint_word_union_search.sv @@
// Takes a list of lower-case words one letter item per cycle, keeps up to MAX_WORDS
// repeat-free words as letter masks in a small memory, and after the last letter runs
// a depth-first search for the largest union of letter-disjoint words. Letters are
// accepted at one per cycle. On the list's last letter the input stalls while the
// search runs: each candidate word examined takes a memory read, then an evaluate
// step, and each backtrack takes a read that finds no candidate left, then a frame
// restore, with up to 2^MAX_WORDS nodes in the search tree in the worst case. The
// search ends early when a union reaches 26 letters. The result then passes to the
// output register once that is free, and waits there; the next list may start
// loading before it is taken. No clearing pass follows reset.
// depends on mdwus_pkg, mdwus_if, mdwus_ram, mdwus_word_builder, mdwus_search

module max_disjoint_word_union_search #(
	parameter int MAX_WORDS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	mdwus_in_if.sink     letters,
	mdwus_out_if.source  result
);

	localparam int CNT_W = $clog2(MAX_WORDS + 1);
	localparam int ADDR_W = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;

	logic accept;
	logic out_free;
	logic wr_en;
	logic [ADDR_W-1:0] wr_addr;
	mdwus_pkg::word_entry_t wr_data;
	logic [ADDR_W-1:0] word_raddr;
	mdwus_pkg::word_entry_t word_rdata;
	logic [CNT_W-1:0] word_count;
	logic overflow;
	mdwus_pkg::srch_status_t srch;

	logic out_valid_q;
	mdwus_pkg::len_t out_len_q;
	logic out_drop_q;

	assign letters.ready = !srch.busy;
	assign accept = letters.valid && letters.ready;
	assign out_free = !out_valid_q || result.ready;

	mdwus_word_builder #(
		.MAX_WORDS(MAX_WORDS),
		.CNT_W(CNT_W),
		.ADDR_W(ADDR_W)
	) u_builder (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.letter_index(letters.letter_index),
		.word_end(letters.word_end),
		.list_end(letters.list_end),
		.clear(srch.done),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.word_count(word_count),
		.overflow(overflow)
	);

	mdwus_ram #(
		.WIDTH(mdwus_pkg::ENTRY_W),
		.DEPTH(MAX_WORDS),
		.ADDR_W(ADDR_W)
	) u_words (
		.clk(clk),
		.we(wr_en),
		.waddr(wr_addr),
		.wdata(wr_data),
		.raddr(word_raddr),
		.rdata(word_rdata)
	);

	mdwus_search #(
		.MAX_WORDS(MAX_WORDS),
		.CNT_W(CNT_W),
		.ADDR_W(ADDR_W)
	) u_search (
		.clk(clk),
		.arst_n(arst_n),
		.start(accept && letters.list_end),
		.out_free(out_free),
		.word_count(word_count),
		.word_raddr(word_raddr),
		.word_rdata(word_rdata),
		.status(srch)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (srch.done) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (srch.done) begin
			out_len_q <= srch.best;
			out_drop_q <= overflow;
		end
	end

	assign result.valid = out_valid_q;
	assign result.max_length = out_len_q;
	assign result.words_dropped = out_drop_q;

endmodule
